>>> design/maf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maf_pkg: shared types and constants of the moving-average filter
// Window geometry, datapath widths, sequencer states and the length clamp.
// ----------------------------------------------------------------------------
package maf_pkg;

  localparam int WINDOW_MAX = 256;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + ADDR_W;
  localparam int DIV_STEPS  = SUM_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN,
    S_FILL,
    S_SUM,
    S_SUMD,
    S_READ,
    S_UPD,
    S_DLOAD,
    S_DIV,
    S_OUT
  } state_t;

  // Clamp the programmed length to 1..WINDOW_MAX
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] w);
    logic [LEN_W-1:0] r;
    if (w == '0) begin
      r = LEN_W'(1);
    end else if (w > LEN_W'(WINDOW_MAX)) begin
      r = LEN_W'(WINDOW_MAX);
    end else begin
      r = w;
    end
    return r;
  endfunction

  // Widen a sample to running-sum width
  function automatic logic signed [SUM_W-1:0] sext(input logic signed [SAMPLE_W-1:0] s);
    return {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
  endfunction

endpackage
`default_nettype wire

>>> design/moving_average_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_filter: boxcar mean over the newest window_len samples
// Ring of samples in a 256x16 synchronous RAM, 24-bit running sum, and a
// radix-2 restoring divider that produces the truncated mean.
// ----------------------------------------------------------------------------
// Sequencing: after a request is taken the window is first adjusted. When it
//   grows, each added slot gets one RAM write of the last mean; when it shrinks,
//   the kept samples are summed anew from the RAM. Then the divider runs.
// Requests do not overlap: a new request is taken only once the block is idle.
// Reset: window empty, sum and last mean zero, window_len = 1; RAM contents
//   stay undefined and are never read before written (no clearing pass).
// ----------------------------------------------------------------------------
module moving_average_filter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // sample channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [maf_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                                in_restart,
  // mean channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [maf_pkg::SAMPLE_W-1:0]      out_average,
  // window length register
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [maf_pkg::LEN_W-1:0]           cfg_window_len
);

  maf_pkg::state_t state_r, state_nxt;

  logic [maf_pkg::LEN_W-1:0]           window_len_r;
  logic signed [maf_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [maf_pkg::ADDR_W-1:0]          newest_r, newest_nxt;
  logic [maf_pkg::LEN_W-1:0]           length_r, length_nxt;
  logic signed [maf_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [maf_pkg::SAMPLE_W-1:0] lavg_r, lavg_nxt;
  logic [maf_pkg::LEN_W-1:0]           len_cur_r, len_cur_nxt;
  logic [maf_pkg::ADDR_W-1:0]          k_r, k_nxt;
  logic                                rd_vld_r;
  logic [maf_pkg::LEN_W-1:0]           rem_r, rem_nxt;
  logic [maf_pkg::SUM_W-1:0]           dq_r, dq_nxt;
  logic                                neg_r, neg_nxt;
  logic [maf_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [maf_pkg::SAMPLE_W-1:0] out_average_r, out_average_nxt;

  // RAM port signals
  logic signed [maf_pkg::SAMPLE_W-1:0] mem [maf_pkg::WINDOW_MAX];
  logic                                mem_we;
  logic [maf_pkg::ADDR_W-1:0]          mem_waddr;
  logic signed [maf_pkg::SAMPLE_W-1:0] mem_wdata;
  logic [maf_pkg::ADDR_W-1:0]          mem_raddr;
  logic signed [maf_pkg::SAMPLE_W-1:0] mem_rdata_r;

  logic                                in_take;
  logic                                out_free;
  logic [maf_pkg::LEN_W-1:0]           len_m1;
  logic [maf_pkg::LEN_W:0]             rem_sh;
  logic [maf_pkg::LEN_W:0]             rem_sub;
  logic                                div_ge;
  logic [maf_pkg::SUM_W-1:0]           q_neg;
  logic signed [maf_pkg::SAMPLE_W-1:0] avg;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign len_m1   = len_cur_r - maf_pkg::LEN_W'(1);

  // Divider step: shift one dividend bit into the partial remainder
  assign rem_sh  = {rem_r, dq_r[maf_pkg::SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, len_cur_r};
  assign div_ge  = rem_sh >= {1'b0, len_cur_r};
  assign q_neg   = -dq_r;
  assign avg     = neg_r ? q_neg[maf_pkg::SAMPLE_W-1:0] : dq_r[maf_pkg::SAMPLE_W-1:0];

  // Configuration register: always writable; the user is to change it only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= maf_pkg::LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      window_len_r <= cfg_window_len;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      maf_pkg::S_IDLE: begin
        if (in_take) state_nxt = maf_pkg::S_PLAN;
      end
      maf_pkg::S_PLAN: begin
        if (length_r < len_cur_r) begin
          state_nxt = maf_pkg::S_FILL;
        end else if (length_r > len_cur_r) begin
          state_nxt = maf_pkg::S_SUM;
        end else begin
          state_nxt = maf_pkg::S_READ;
        end
      end
      maf_pkg::S_FILL: begin
        if (k_r == len_m1[maf_pkg::ADDR_W-1:0]) state_nxt = maf_pkg::S_READ;
      end
      maf_pkg::S_SUM: begin
        if (k_r == len_m1[maf_pkg::ADDR_W-1:0]) state_nxt = maf_pkg::S_SUMD;
      end
      maf_pkg::S_SUMD:  state_nxt = maf_pkg::S_READ;
      maf_pkg::S_READ:  state_nxt = maf_pkg::S_UPD;
      maf_pkg::S_UPD:   state_nxt = maf_pkg::S_DLOAD;
      maf_pkg::S_DLOAD: state_nxt = maf_pkg::S_DIV;
      maf_pkg::S_DIV: begin
        if (cnt_r == maf_pkg::CNT_W'(maf_pkg::DIV_STEPS - 1)) state_nxt = maf_pkg::S_OUT;
      end
      maf_pkg::S_OUT: begin
        if (out_free) state_nxt = maf_pkg::S_IDLE;
      end
      default: state_nxt = maf_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and RAM port
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = newest_r - k_r;
    mem_wdata = lavg_r;
    mem_raddr = newest_r - k_r;
    unique case (state_r)
      maf_pkg::S_IDLE: in_stall = 1'b0;
      maf_pkg::S_FILL: mem_we = 1'b1;
      maf_pkg::S_READ: mem_raddr = newest_r - len_m1[maf_pkg::ADDR_W-1:0];
      maf_pkg::S_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = newest_r + maf_pkg::ADDR_W'(1);
        mem_wdata = sample_r;
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    sample_nxt      = sample_r;
    newest_nxt      = newest_r;
    length_nxt      = length_r;
    sum_nxt         = sum_r;
    lavg_nxt        = lavg_r;
    len_cur_nxt     = len_cur_r;
    k_nxt           = k_r;
    rem_nxt         = rem_r;
    dq_nxt          = dq_r;
    neg_nxt         = neg_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_average_nxt = out_average_r;
    case (state_r)
      maf_pkg::S_IDLE: begin
        if (in_take) begin
          sample_nxt  = in_sample;
          len_cur_nxt = maf_pkg::eff_len(window_len_r);
          // restart empties the window and seeds the mean
          if (in_restart) begin
            length_nxt = '0;
            sum_nxt    = '0;
            lavg_nxt   = in_sample;
          end
        end
      end
      maf_pkg::S_PLAN: begin
        if (length_r < len_cur_r) begin
          k_nxt = length_r[maf_pkg::ADDR_W-1:0];
        end else if (length_r > len_cur_r) begin
          k_nxt   = '0;
          sum_nxt = '0;
        end
      end
      // grow: pad the older slots with the last mean
      maf_pkg::S_FILL: begin
        sum_nxt = sum_r + maf_pkg::sext(lavg_r);
        k_nxt   = k_r + maf_pkg::ADDR_W'(1);
        if (k_r == len_m1[maf_pkg::ADDR_W-1:0]) length_nxt = len_cur_r;
      end
      // shrink: re-add the kept samples, read data arrives in the cycle after its address
      maf_pkg::S_SUM, maf_pkg::S_SUMD: begin
        if (rd_vld_r) sum_nxt = sum_r + maf_pkg::sext(mem_rdata_r);
        k_nxt = k_r + maf_pkg::ADDR_W'(1);
        if (state_r == maf_pkg::S_SUMD) length_nxt = len_cur_r;
      end
      // drop the oldest sample, add the new one
      maf_pkg::S_UPD: begin
        sum_nxt    = sum_r - maf_pkg::sext(mem_rdata_r) + maf_pkg::sext(sample_r);
        newest_nxt = newest_r + maf_pkg::ADDR_W'(1);
      end
      maf_pkg::S_DLOAD: begin
        neg_nxt = sum_r[maf_pkg::SUM_W-1];
        dq_nxt  = sum_r[maf_pkg::SUM_W-1] ? maf_pkg::SUM_W'(-sum_r) : maf_pkg::SUM_W'(sum_r);
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      maf_pkg::S_DIV: begin
        rem_nxt = div_ge ? rem_sub[maf_pkg::LEN_W-1:0] : rem_sh[maf_pkg::LEN_W-1:0];
        dq_nxt  = {dq_r[maf_pkg::SUM_W-2:0], div_ge};
        cnt_nxt = cnt_r + maf_pkg::CNT_W'(1);
      end
      maf_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_average_nxt = avg;
          lavg_nxt        = avg;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= maf_pkg::S_IDLE;
      newest_r    <= '0;
      length_r    <= '0;
      sum_r       <= '0;
      lavg_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      length_r    <= length_nxt;
      sum_r       <= sum_nxt;
      lavg_r      <= lavg_nxt;
      rd_vld_r    <= (state_r == maf_pkg::S_SUM);
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sample_r      <= sample_nxt;
    len_cur_r     <= len_cur_nxt;
    k_r           <= k_nxt;
    rem_r         <= rem_nxt;
    dq_r          <= dq_nxt;
    neg_r         <= neg_nxt;
    cnt_r         <= cnt_nxt;
    out_average_r <= out_average_nxt;
  end

  // Sample ring RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= maf_pkg::LEN_W'(maf_pkg::WINDOW_MAX))
    else $error("window length in use exceeds ring depth");

  a_len_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == maf_pkg::S_DLOAD) |-> (length_r == len_cur_r))
    else $error("window length not settled before division");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == maf_pkg::S_DIV) |-> (cnt_r < maf_pkg::CNT_W'(maf_pkg::DIV_STEPS)))
    else $error("divider step count overrun");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == maf_pkg::S_OUT))
    else $error("result raised outside output state");

  a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == maf_pkg::S_DIV) |-> (rem_r < len_cur_r))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the moving-average filter
// A scoreboard class predicts the mean of every accepted sample request.
// Stimulus: a directed pass over the field and window-length corners, then
// random phases that each set a new window length and stream a batch of
// samples. The sender idles in bursts and the receiver stalls on its own.
// ----------------------------------------------------------------------------
module tb_top;

  // Predicts the mean of each request and holds the means still to come
  class mean_scoreboard;
    logic signed [maf_pkg::SAMPLE_W-1:0] ring [maf_pkg::WINDOW_MAX];
    logic [maf_pkg::ADDR_W-1:0]          head;
    logic [maf_pkg::LEN_W-1:0]           fill_len;
    logic [maf_pkg::LEN_W-1:0]           win_len;
    logic signed [maf_pkg::SUM_W-1:0]    total;
    logic signed [maf_pkg::SAMPLE_W-1:0] last_mean;
    logic signed [maf_pkg::SAMPLE_W-1:0] expected_means [$];
    int                                  errors;

    function new();
      head      = '0;
      fill_len  = '0;
      win_len   = maf_pkg::LEN_W'(1);
      total     = '0;
      last_mean = '0;
      errors    = 0;
    endfunction

    function void set_window(logic [maf_pkg::LEN_W-1:0] v);
      win_len = v;
    endfunction

    // slot k places older than the newest one
    function logic [maf_pkg::ADDR_W-1:0] older(int k);
      return maf_pkg::ADDR_W'(int'(head) - k);
    endfunction

    function void note_sample(logic signed [maf_pkg::SAMPLE_W-1:0] smp, logic restart);
      int len;
      int k;
      if (restart) begin
        fill_len  = '0;
        total     = '0;
        last_mean = smp;
      end
      // length 0 acts as 1, anything past the ring size as the ring size
      len = (win_len == 0) ? 1 :
            (win_len > maf_pkg::WINDOW_MAX) ? maf_pkg::WINDOW_MAX : int'(win_len);
      if (fill_len < len) begin
        // grown (or empty) window: new oldest slots take the last mean
        for (k = int'(fill_len); k < len; k++) begin
          ring[older(k)] = last_mean;
          total += last_mean;
        end
        fill_len = maf_pkg::LEN_W'(len);
      end else if (fill_len > len) begin
        // shrunk window: oldest samples drop out, sum rebuilt from the rest
        total = '0;
        for (k = 0; k < len; k++) begin
          total += ring[older(k)];
        end
        fill_len = maf_pkg::LEN_W'(len);
      end
      total = total - ring[older(len - 1)] + smp;
      head = head + 1'b1;
      ring[head] = smp;
      last_mean = maf_pkg::SAMPLE_W'(int'(total) / len);
      expected_means.insert(expected_means.size(), last_mean);
    endfunction

    function void check_mean(logic signed [maf_pkg::SAMPLE_W-1:0] got);
      logic signed [maf_pkg::SAMPLE_W-1:0] want;
      if (expected_means.size() == 0) begin
        $display("%0t: average %0d arrived with no request pending", $time, got);
        errors++;
        return;
      end
      want = expected_means.pop_front();
      if (got !== want) begin
        $display("%0t: average mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [maf_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                                in_restart = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [maf_pkg::SAMPLE_W-1:0] out_average;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [maf_pkg::LEN_W-1:0]           cfg_window_len = maf_pkg::LEN_W'(1);

  mean_scoreboard sb = new();
  int             burst_left = 0;
  int             sent = 0;

  moving_average_filter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average    (out_average),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_window_len (cfg_window_len)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Monitor: note accepted requests, config writes and results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_window(cfg_window_len);
      end
      if (in_valid && !in_stall) begin
        sb.note_sample(in_sample, in_restart);
      end
      if (out_valid && !out_stall) begin
        sb.check_mean(out_average);
      end
    end
  end

  // Receiver: stretches of free flow, light, heavy and full stall
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall <= 1'b1;
          end
        endcase
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return 0;
    end else if (r < 8) begin
      return $urandom_range(1, 4);
    end else begin
      return $urandom_range(10, 45);
    end
  endfunction

  function automatic logic signed [maf_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        return 16'sh7fff;
      end
      1: begin
        return 16'sh8000;
      end
      2: begin
        return maf_pkg::SAMPLE_W'($urandom_range(0, 16) - 8);
      end
      default: begin
        return maf_pkg::SAMPLE_W'($urandom);
      end
    endcase
  endfunction

  function automatic logic [maf_pkg::LEN_W-1:0] pick_window();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: begin
        return '0;
      end
      1: begin
        return maf_pkg::LEN_W'(maf_pkg::WINDOW_MAX);
      end
      2: begin
        return maf_pkg::LEN_W'($urandom_range(maf_pkg::WINDOW_MAX + 1, 511));
      end
      3: begin
        return maf_pkg::LEN_W'(maf_pkg::WINDOW_MAX - 1);
      end
      4: begin
        return maf_pkg::LEN_W'($urandom);
      end
      5, 6, 7: begin
        return maf_pkg::LEN_W'($urandom_range(9, 40));
      end
      default: begin
        return maf_pkg::LEN_W'($urandom_range(1, 8));
      end
    endcase
  endfunction

  // One sample request; a new burst may open with an idle gap
  task automatic send_sample(logic signed [maf_pkg::SAMPLE_W-1:0] s, logic r);
    int gap;
    if (burst_left == 0) begin
      gap = pick_gap();
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_sample  <= s;
    in_restart <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Close the request stream and wait for every pending mean; the extra
  // edge lets the monitor log the last accepted request first
  task automatic finish_phase();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_means.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(logic [maf_pkg::LEN_W-1:0] v);
    cfg_valid      <= 1'b1;
    cfg_window_len <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length 1, first sample after reset, sample extremes
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    finish_phase();
    // grow to 4, restart seeding, negative truncation
    write_window(maf_pkg::LEN_W'(4));
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh04d2, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd7, 1'b0);
    finish_phase();
    // zero length acts as one, shrinks the window
    write_window('0);
    send_sample(16'sd7, 1'b0);
    send_sample(-16'sd7, 1'b0);
    finish_phase();
    // full ring, filled from the last mean, then extremes through it
    write_window(maf_pkg::LEN_W'(maf_pkg::WINDOW_MAX));
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    finish_phase();
    // beyond the ring size acts as the ring size
    write_window(maf_pkg::LEN_W'(511));
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    finish_phase();
    // shrink from full ring
    write_window(maf_pkg::LEN_W'(3));
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(-16'sd3, 1'b0);
    finish_phase();

    // random phases: new length, then a batch of samples
    while (sent < 400) begin
      write_window(pick_window());
      n = $urandom_range(8, 30);
      repeat (n) begin
        send_sample(pick_sample(), ($urandom_range(0, 15) == 0));
        sent++;
      end
      finish_phase();
    end

    // catch late or stray results
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.expected_means.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
